@@ sv/gmlct_pkg.sv @@
// ----------------------------------------------------------------------------
// gmlct_pkg
// Types and fixed constants shared by the gamma/matrix/LUT color transform.
// ----------------------------------------------------------------------------
package gmlct_pkg;

  // Number of color channels that carry tables and matrix columns.
  localparam int CHANNELS    = 3;

  // Input gamma tables: 256 entries of unsigned Q1.16 per channel.
  localparam int GAMMA_DEPTH = 256;
  localparam int GAMMA_AW    = 8;
  localparam int GAMMA_W     = 17;

  // Matrix coefficients are signed Q2.14, packed three to a 48-bit row.
  localparam int COEF_W      = 16;
  localparam int ROW_W       = 48;
  localparam int CFG_IDX_W   = 2;

  // Product of an unsigned Q1.16 and a signed Q2.14, and the sum of three.
  localparam int PROD_W      = 34;
  localparam int SUM_W       = 36;

  // Saturated non-negative Q.30 sum: 0 .. 2^30 inclusive.
  localparam int SAT_W       = 31;
  localparam int Q30_SHIFT   = 30;
  localparam int ROUND_HALF  = 1 << 29;
  localparam logic [SAT_W-1:0] SAT_MAX = {1'b1, {(SAT_W-1){1'b0}}};

  // Table write fields.
  localparam int TIDX_W      = 13;
  localparam int TVAL_W      = 17;
  localparam logic [1:0] CH_LAST = 2'd2;

  // Matrix row reset values form the identity matrix.
  localparam logic [ROW_W-1:0] ROW_RED_RST   = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_GREEN_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_BLUE_RST  = 48'h4000_0000_0000;

  // Item kinds carried in the action field.
  typedef enum logic [1:0] {
    ACT_PIXEL  = 2'd0,
    ACT_GAMMA  = 2'd1,
    ACT_OUTPUT = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_RED   = 2'd0,
    CFG_ROW_GREEN = 2'd1,
    CFG_ROW_BLUE  = 2'd2
  } cfg_idx_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              end_of_run;
    logic [1:0]        table_channel;
    logic [TIDX_W-1:0] table_index;
    logic [TVAL_W-1:0] table_value;
  } pix_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       end_of_run_out;
  } res_t;

  // Side information that travels down the pipeline with each item.
  typedef struct packed {
    logic              is_pix;
    logic [7:0]        alpha;
    logic              eor;
    logic [1:0]        ochan;
    logic [TIDX_W-1:0] oidx;
    logic [7:0]        oval;
  } side_t;

  // After the gamma lookup.
  typedef struct packed {
    logic [CHANNELS-1:0][GAMMA_W-1:0] gam;
    side_t                            side;
  } gam_t;

  // After the matrix multiply and saturation.
  typedef struct packed {
    logic [CHANNELS-1:0][SAT_W-1:0] sat;
    side_t                          side;
  } sat_t;

endpackage

@@ sv/gmlct_if.sv @@
// ----------------------------------------------------------------------------
// gmlct_pix_if / gmlct_res_if
// Valid/ready stream channels for the pixel input and the result output.
// ----------------------------------------------------------------------------
interface gmlct_pix_if;
  logic            valid;
  logic            ready;
  gmlct_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gmlct_res_if;
  logic            valid;
  logic            ready;
  gmlct_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/gamma_matrix_lut_color_transform.sv @@
// ----------------------------------------------------------------------------
// gamma_matrix_lut_color_transform
// Gamma lookup, 3x3 matrix and output lookup color transform, top level.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one beat per item: a pixel, a gamma table write or an
//   output table write (selected by action). Only pixel beats produce a
//   beat on res_o, in the order they were accepted; table writes retire
//   inside the pipeline and stay ordered with the pixels around them.
//   The matrix rows are loaded through cfg_we_i/cfg_idx_i/cfg_data_i while
//   no item is in flight.
//   There are five register stages: gamma lookup, products, sums with
//   saturation, index scaling, output lookup. Throughput is one item per
//   cycle while res_o is not stalled; each stage is one register deep and
//   the products are formed by nine parallel 18x16 multipliers.
//   When res_o is stalled, beats collect in the empty stages, so up to five
//   pixels are held before pix_i.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the identity matrix. Table
//   contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module gamma_matrix_lut_color_transform #(
  parameter int OUT_TABLE_SIZE = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gmlct_pix_if.sink                       pix_i,
  gmlct_res_if.source                     res_o,
  input  logic                            cfg_we_i,
  input  logic [gmlct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gmlct_pkg::ROW_W-1:0]     cfg_data_i
);

  localparam int IDX_W = $clog2(OUT_TABLE_SIZE);

  logic                                      gam_valid, gam_ready;
  gmlct_pkg::gam_t                           gam_beat;
  logic                                      sat_valid, sat_ready;
  gmlct_pkg::sat_t                           sat_beat;
  logic                                      idx_valid, idx_ready;
  logic [gmlct_pkg::CHANNELS-1:0][IDX_W-1:0] idx;
  gmlct_pkg::side_t                          idx_side;

  // Input gamma lookup.
  gmlct_gamma_lookup u_gamma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_beat_i   (pix_i.data),
    .out_valid_o (gam_valid),
    .out_ready_i (gam_ready),
    .out_beat_o  (gam_beat)
  );

  // Matrix multiply and saturation.
  gmlct_matrix_mult u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (gam_valid),
    .in_ready_o  (gam_ready),
    .in_beat_i   (gam_beat),
    .out_valid_o (sat_valid),
    .out_ready_i (sat_ready),
    .out_beat_o  (sat_beat)
  );

  // Output table index.
  gmlct_out_index #(
    .OUT_TABLE_SIZE (OUT_TABLE_SIZE)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sat_valid),
    .in_ready_o  (sat_ready),
    .in_beat_i   (sat_beat),
    .out_valid_o (idx_valid),
    .out_ready_i (idx_ready),
    .out_idx_o   (idx),
    .out_side_o  (idx_side)
  );

  // Output table lookup and result register.
  gmlct_out_lookup #(
    .OUT_TABLE_SIZE (OUT_TABLE_SIZE)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (idx_valid),
    .in_ready_o  (idx_ready),
    .in_idx_i    (idx),
    .in_side_i   (idx_side),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_beat_o  (res_o.data)
  );

endmodule

@@ sv/gmlct_gamma_lookup.sv @@
// ----------------------------------------------------------------------------
// gmlct_gamma_lookup
// First pipeline stage: input gamma table writes and registered lookups.
// ----------------------------------------------------------------------------
module gmlct_gamma_lookup (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gmlct_pkg::pix_t in_beat_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gmlct_pkg::gam_t out_beat_o
);

  logic                  valid_q, valid_d;
  gmlct_pkg::side_t      side_q;
  logic                  accept;
  logic                  is_pix;
  logic                  is_owr;
  logic                  gam_we;
  logic [gmlct_pkg::CHANNELS-1:0][7:0] comp;

  // The stage takes a beat when it is empty or its content moves on.
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the item kind.
  assign is_pix = accept && (in_beat_i.action == gmlct_pkg::ACT_PIXEL);
  assign is_owr = accept && (in_beat_i.action == gmlct_pkg::ACT_OUTPUT);
  assign gam_we = accept && (in_beat_i.action == gmlct_pkg::ACT_GAMMA) &&
                  (in_beat_i.table_channel <= gmlct_pkg::CH_LAST) &&
                  (in_beat_i.table_index[gmlct_pkg::TIDX_W-1:gmlct_pkg::GAMMA_AW] == '0);

  assign comp[0] = in_beat_i.red;
  assign comp[1] = in_beat_i.green;
  assign comp[2] = in_beat_i.blue;

  // Only pixels and output table writes continue down the pipeline.
  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = is_pix || is_owr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Side information follows the beat.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      side_q.is_pix <= in_beat_i.action == gmlct_pkg::ACT_PIXEL;
      side_q.alpha  <= in_beat_i.alpha;
      side_q.eor    <= in_beat_i.end_of_run;
      side_q.ochan  <= in_beat_i.table_channel;
      side_q.oidx   <= in_beat_i.table_index;
      side_q.oval   <= in_beat_i.table_value[7:0];
    end
  end

  // One gamma memory per channel, one write and one registered read port.
  for (genvar c = 0; c < gmlct_pkg::CHANNELS; c++) begin : g_gamma
    logic [gmlct_pkg::GAMMA_W-1:0] mem [gmlct_pkg::GAMMA_DEPTH];
    logic [gmlct_pkg::GAMMA_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (gam_we && (in_beat_i.table_channel == 2'(c))) begin
        mem[in_beat_i.table_index[gmlct_pkg::GAMMA_AW-1:0]] <= in_beat_i.table_value;
      end
      if (is_pix) begin
        rd_q <= mem[comp[c]];
      end
    end

    assign out_beat_o.gam[c] = rd_q;
  end

  assign out_valid_o     = valid_q;
  assign out_beat_o.side = side_q;

endmodule

@@ sv/gmlct_matrix_mult.sv @@
// ----------------------------------------------------------------------------
// gmlct_matrix_mult
// Matrix registers, a product stage and a sum-and-saturate stage.
// ----------------------------------------------------------------------------
module gmlct_matrix_mult (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gmlct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmlct_pkg::ROW_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  gmlct_pkg::gam_t                      in_beat_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output gmlct_pkg::sat_t                      out_beat_o
);

  localparam int NC = gmlct_pkg::CHANNELS;

  logic [gmlct_pkg::ROW_W-1:0]         row_q [NC];
  logic                                prd_valid_q, prd_valid_d;
  logic                                sum_valid_q, sum_valid_d;
  logic                                prd_ready;
  logic                                sum_ready;
  logic signed [gmlct_pkg::PROD_W-1:0] prod_d [NC][NC];
  logic signed [gmlct_pkg::PROD_W-1:0] prod_q [NC][NC];
  logic signed [gmlct_pkg::SUM_W-1:0]  sum_d [NC];
  logic [NC-1:0][gmlct_pkg::SAT_W-1:0] sat_d;
  gmlct_pkg::side_t                    prd_side_q;
  gmlct_pkg::sat_t                     sum_beat_q;

  // Matrix rows, to be written only while the pipeline is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= gmlct_pkg::ROW_RED_RST;
      row_q[1] <= gmlct_pkg::ROW_GREEN_RST;
      row_q[2] <= gmlct_pkg::ROW_BLUE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gmlct_pkg::CFG_ROW_RED:   row_q[0] <= cfg_data_i;
        gmlct_pkg::CFG_ROW_GREEN: row_q[1] <= cfg_data_i;
        gmlct_pkg::CFG_ROW_BLUE:  row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshakes: each stage moves when empty or when its successor takes.
  assign sum_ready  = !sum_valid_q || out_ready_i;
  assign prd_ready  = !prd_valid_q || sum_ready;
  assign in_ready_o = prd_ready;

  // Nine products of a linear value and a signed coefficient.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int j = 0; j < NC; j++) begin
        prod_d[c][j] = $signed({1'b0, in_beat_i.gam[c]}) *
                       $signed(row_q[c][gmlct_pkg::COEF_W*j +: gmlct_pkg::COEF_W]);
      end
    end
  end

  // Column sums, saturated to the range 0 .. 2^30.
  always_comb begin
    for (int j = 0; j < NC; j++) begin
      sum_d[j] = gmlct_pkg::SUM_W'(prod_q[0][j]) + gmlct_pkg::SUM_W'(prod_q[1][j]) +
                 gmlct_pkg::SUM_W'(prod_q[2][j]);
      if (sum_d[j][gmlct_pkg::SUM_W-1] || (sum_d[j] == '0)) begin
        sat_d[j] = '0;
      end else if (|sum_d[j][gmlct_pkg::SUM_W-2:gmlct_pkg::Q30_SHIFT]) begin
        sat_d[j] = gmlct_pkg::SAT_MAX;
      end else begin
        sat_d[j] = {1'b0, sum_d[j][gmlct_pkg::Q30_SHIFT-1:0]};
      end
    end
  end

  // Valid bits.
  always_comb begin
    prd_valid_d = prd_valid_q;
    sum_valid_d = sum_valid_q;
    if (prd_ready) begin
      prd_valid_d = in_valid_i;
    end
    if (sum_ready) begin
      sum_valid_d = prd_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      prd_valid_q <= prd_valid_d;
      sum_valid_q <= sum_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (prd_ready) begin
      prod_q     <= prod_d;
      prd_side_q <= in_beat_i.side;
    end
    if (sum_ready) begin
      sum_beat_q.sat  <= sat_d;
      sum_beat_q.side <= prd_side_q;
    end
  end

  assign out_valid_o = sum_valid_q;
  assign out_beat_o  = sum_beat_q;

endmodule

@@ sv/gmlct_out_index.sv @@
// ----------------------------------------------------------------------------
// gmlct_out_index
// Scales a saturated Q.30 sum to an output table index, rounded half-up and clamped.
// ----------------------------------------------------------------------------
module gmlct_out_index #(
  parameter int OUT_TABLE_SIZE = 8192
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  gmlct_pkg::sat_t                        in_beat_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [gmlct_pkg::CHANNELS-1:0][$clog2(OUT_TABLE_SIZE)-1:0] out_idx_o,
  output gmlct_pkg::side_t                       out_side_o
);

  localparam int NC    = gmlct_pkg::CHANNELS;
  localparam int IDX_W = $clog2(OUT_TABLE_SIZE);
  localparam int SZ_W  = $clog2(OUT_TABLE_SIZE + 1);
  localparam int SCL_W = gmlct_pkg::SAT_W + SZ_W;
  localparam int FUL_W = SCL_W - gmlct_pkg::Q30_SHIFT;

  logic                            valid_q, valid_d;
  logic [SCL_W-1:0]                scaled [NC];
  logic [SCL_W-1:0]                rounded [NC];
  logic [FUL_W-1:0]                full [NC];
  logic [NC-1:0][IDX_W-1:0]        idx_d;
  logic [NC-1:0][IDX_W-1:0]        idx_q;
  gmlct_pkg::side_t                side_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // Multiply by the table size, add one half, keep the integer part and clamp it.
  always_comb begin
    for (int j = 0; j < NC; j++) begin
      scaled[j]  = SCL_W'(in_beat_i.sat[j]) * SCL_W'(OUT_TABLE_SIZE);
      rounded[j] = scaled[j] + SCL_W'(gmlct_pkg::ROUND_HALF);
      full[j]    = rounded[j][SCL_W-1:gmlct_pkg::Q30_SHIFT];
      if (full[j] > FUL_W'(OUT_TABLE_SIZE - 1)) begin
        idx_d[j] = IDX_W'(OUT_TABLE_SIZE - 1);
      end else begin
        idx_d[j] = full[j][IDX_W-1:0];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      idx_q  <= idx_d;
      side_q <= in_beat_i.side;
    end
  end

  assign out_valid_o = valid_q;
  assign out_idx_o   = idx_q;
  assign out_side_o  = side_q;

endmodule

@@ sv/gmlct_out_lookup.sv @@
// ----------------------------------------------------------------------------
// gmlct_out_lookup
// Last stage: output table writes and registered output byte lookups.
// ----------------------------------------------------------------------------
module gmlct_out_lookup #(
  parameter int OUT_TABLE_SIZE = 8192
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [gmlct_pkg::CHANNELS-1:0][$clog2(OUT_TABLE_SIZE)-1:0] in_idx_i,
  input  gmlct_pkg::side_t                       in_side_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output gmlct_pkg::res_t                        out_beat_o
);

  localparam int NC    = gmlct_pkg::CHANNELS;
  localparam int IDX_W = $clog2(OUT_TABLE_SIZE);

  logic              valid_q, valid_d;
  logic              adv;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [7:0]        alpha_q;
  logic              eor_q;
  logic [NC-1:0][7:0] byte_q;

  // Only pixels occupy the output register; writes retire here.
  assign in_ready_o = !valid_q || out_ready_i;
  assign adv        = in_valid_i && in_ready_o;
  assign rd_en      = adv && in_side_i.is_pix;
  assign wr_en      = adv && !in_side_i.is_pix &&
                      (in_side_i.ochan <= gmlct_pkg::CH_LAST) &&
                      (32'(in_side_i.oidx) < 32'(OUT_TABLE_SIZE));
  assign wr_addr    = IDX_W'(in_side_i.oidx);

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = rd_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Pass-through fields of the pixel.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      alpha_q <= in_side_i.alpha;
      eor_q   <= in_side_i.eor;
    end
  end

  // One output table per channel, one write and one registered read port.
  for (genvar c = 0; c < NC; c++) begin : g_out
    logic [7:0] mem [OUT_TABLE_SIZE];

    always_ff @(posedge clk_i) begin
      if (wr_en && (in_side_i.ochan == 2'(c))) begin
        mem[wr_addr] <= in_side_i.oval;
      end
      if (rd_en) begin
        byte_q[c] <= mem[in_idx_i[c]];
      end
    end
  end

  assign out_valid_o               = valid_q;
  assign out_beat_o.red_out        = byte_q[0];
  assign out_beat_o.green_out      = byte_q[1];
  assign out_beat_o.blue_out       = byte_q[2];
  assign out_beat_o.alpha_out      = alpha_q;
  assign out_beat_o.end_of_run_out = eor_q;

endmodule

@@ sv/gmlct_checker.sv @@
// ----------------------------------------------------------------------------
// gmlct_checker
// Port-level checks of the color transform, attached to the top by bind.
// ----------------------------------------------------------------------------
module gmlct_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic [1:0]      in_action_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input gmlct_pkg::res_t out_beat_i
);

  logic [3:0] pending_q, pending_d;
  logic       pix_acc;
  logic       res_acc;

  // Track pixels accepted but not yet delivered.
  assign pix_acc = in_valid_i && in_ready_i && (in_action_i == gmlct_pkg::ACT_PIXEL);
  assign res_acc = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (pix_acc && !res_acc) begin
      pending_d = pending_q + 4'd1;
    end else if (!pix_acc && res_acc) begin
      pending_d = pending_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled result beat stays and holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("result beat changed while stalled");

  // No result appears without a pixel to account for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result without a pending pixel");

  // The pipeline never holds more pixels than it has stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd5)
    else $error("too many pixels in flight");

  // With the result register empty every stage can move, so input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output is empty");

endmodule

bind gamma_matrix_lut_color_transform gmlct_checker u_gmlct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_action_i (pix_i.data.action),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_beat_i  (res_o.data)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gamma / matrix / output-table color transform.
// Table entries are written on demand just before the first pixel that reads
// them, so no pixel ever reads an entry that was never written. Table loads
// come first, then special cases, several matrix settings and mixed random
// traffic. A local predictor computes every result beat, and each beat on
// res_o is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OUT_SIZE       = 8192;
  localparam int PIPE_LATENCY   = 5;
  localparam int RANDOM_ITEMS   = 300;
  localparam int RELOAD_EVERY   = 75;
  localparam int SETTING_PIXELS = 12;

  localparam int CHANNELS    = gmlct_pkg::CHANNELS;
  localparam int GAMMA_DEPTH = gmlct_pkg::GAMMA_DEPTH;
  localparam int GAMMA_AW    = gmlct_pkg::GAMMA_AW;
  localparam int GAMMA_W     = gmlct_pkg::GAMMA_W;
  localparam int COEF_W      = gmlct_pkg::COEF_W;
  localparam int ROW_W       = gmlct_pkg::ROW_W;
  localparam int CFG_IDX_W   = gmlct_pkg::CFG_IDX_W;
  localparam int TIDX_W      = gmlct_pkg::TIDX_W;
  localparam int TVAL_W      = gmlct_pkg::TVAL_W;

  // Table channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = gmlct_pkg::CH_LAST;

  // Codes the block ignores; they have no name in the package.
  localparam logic [1:0]           ACT_UNUSED     = 2'd3;
  localparam logic [1:0]           CH_NONE        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {PACE_FREE, PACE_COIN, PACE_SPARSE, PACE_HOLD} pace_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ROW_W-1:0]     cfg_data_i;

  gmlct_pix_if pix_if ();
  gmlct_res_if res_if ();

  gamma_matrix_lut_color_transform #(
    .OUT_TABLE_SIZE (OUT_SIZE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Local copy of the block's tables and matrix, with marks of written entries.
  logic [GAMMA_W-1:0] gamma_mirror  [CHANNELS][GAMMA_DEPTH];
  logic [7:0]         lut_mirror    [CHANNELS][OUT_SIZE];
  logic [ROW_W-1:0]   matrix_mirror [CHANNELS];
  bit                 gamma_written [CHANNELS][GAMMA_DEPTH];
  bit                 lut_written   [CHANNELS][OUT_SIZE];

  // Transformed pixels still on their way out of the block.
  gmlct_pkg::res_t pixels_in_flight [$];
  int              mismatch_count;
  int              burst_left;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side backpressure: a pattern that changes its character now and then.
  initial begin : sink_pace
    pace_e mode;
    int    span;
    res_if.ready <= 1'b0;
    forever begin
      mode = pace_e'($urandom_range(0, 3));
      span = (mode == PACE_HOLD) ? $urandom_range(1, 20) : $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          PACE_FREE:   res_if.ready <= 1'b1;
          PACE_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:     res_if.ready <= 1'b0;
        endcase
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    gmlct_pkg::res_t want;
    gmlct_pkg::res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pixels_in_flight.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with no pixel pending: %h", $realtime, got);
      end else begin
        want = pixels_in_flight.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected rgbae %h %h %h %h %b, actual %h %h %h %h %b",
                     $realtime, want.red_out, want.green_out, want.blue_out,
                     want.alpha_out, want.end_of_run_out, got.red_out, got.green_out,
                     got.blue_out, got.alpha_out, got.end_of_run_out);
        end
      end
    end
  end

  // Output table index of channel j: exact matrix product, rounded and clamped.
  function automatic int lut_index(gmlct_pkg::pix_t p, int j);
    longint  lin [CHANNELS];
    longint  acc;
    longint  scaled;
    shortint coef;
    lin[0] = longint'(gamma_mirror[0][p.red]);
    lin[1] = longint'(gamma_mirror[1][p.green]);
    lin[2] = longint'(gamma_mirror[2][p.blue]);
    acc = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      coef = matrix_mirror[c][COEF_W*j +: COEF_W];
      acc += lin[c] * coef;
    end
    if (acc <= 0) return 0;
    scaled = (acc * OUT_SIZE + gmlct_pkg::ROUND_HALF) >>> gmlct_pkg::Q30_SHIFT;
    if (scaled > OUT_SIZE - 1) scaled = OUT_SIZE - 1;
    return int'(scaled);
  endfunction

  // Gamma lookup, matrix and output lookup of one pixel.
  function automatic gmlct_pkg::res_t transform_pixel(gmlct_pkg::pix_t p);
    logic [7:0]      comp [CHANNELS];
    gmlct_pkg::res_t r;
    for (int j = 0; j < CHANNELS; j++) comp[j] = lut_mirror[j][lut_index(p, j)];
    r.red_out        = comp[0];
    r.green_out      = comp[1];
    r.blue_out       = comp[2];
    r.alpha_out      = p.alpha;
    r.end_of_run_out = p.end_of_run;
    return r;
  endfunction

  // Apply one accepted beat to the local copy.
  function automatic void absorb_beat(gmlct_pkg::pix_t b);
    case (b.action)
      gmlct_pkg::ACT_GAMMA: begin
        if (b.table_channel <= gmlct_pkg::CH_LAST && b.table_index < GAMMA_DEPTH) begin
          gamma_mirror[b.table_channel][b.table_index[GAMMA_AW-1:0]]  = b.table_value;
          gamma_written[b.table_channel][b.table_index[GAMMA_AW-1:0]] = 1'b1;
        end
      end
      gmlct_pkg::ACT_OUTPUT: begin
        if (b.table_channel <= gmlct_pkg::CH_LAST && b.table_index < OUT_SIZE) begin
          lut_mirror[b.table_channel][b.table_index]  = b.table_value[7:0];
          lut_written[b.table_channel][b.table_index] = 1'b1;
        end
      end
      gmlct_pkg::ACT_PIXEL: begin
        pixels_in_flight.push_back(transform_pixel(b));
      end
      default: ;
    endcase
  endfunction

  function automatic gmlct_pkg::pix_t random_beat();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(gmlct_pkg::pix_t)-1:0];
  endfunction

  function automatic gmlct_pkg::pix_t pixel_beat(logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b, logic [7:0] a,
                                                 logic eor);
    gmlct_pkg::pix_t p;
    p            = random_beat();
    p.action     = gmlct_pkg::ACT_PIXEL;
    p.red        = r;
    p.green      = g;
    p.blue       = b;
    p.alpha      = a;
    p.end_of_run = eor;
    return p;
  endfunction

  function automatic gmlct_pkg::pix_t table_beat(logic [1:0] act, logic [1:0] ch,
                                                 logic [TIDX_W-1:0] idx,
                                                 logic [TVAL_W-1:0] val);
    gmlct_pkg::pix_t p;
    p               = random_beat();
    p.action        = act;
    p.table_channel = ch;
    p.table_index   = idx;
    p.table_value   = val;
    return p;
  endfunction

  // Mostly at or below one, now and then above it.
  function automatic logic [TVAL_W-1:0] gamma_value();
    if ($urandom_range(0, 7) == 0) return TVAL_W'($urandom_range(65537, 131071));
    return TVAL_W'($urandom_range(0, 65536));
  endfunction

  // Three coefficients, mostly in a useful range, sometimes anything.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] row;
    for (int j = 0; j < CHANNELS; j++) begin
      case ($urandom_range(0, 3))
        0:       row[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(0, 16384));
        1:       row[COEF_W*j +: COEF_W] = COEF_W'(0 - $urandom_range(0, 8192));
        2:       row[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(0, 6000));
        default: row[COEF_W*j +: COEF_W] = COEF_W'($urandom());
      endcase
    end
    return row;
  endfunction

  // Send one beat, in bursts of random length separated by random gaps.
  task automatic push_beat(gmlct_pkg::pix_t b);
    if (burst_left == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 128)
                                                : $urandom_range(1, 12);
    end
    pix_if.data  <= b;
    pix_if.valid <= 1'b1;
    do @(posedge clk_i); while (!pix_if.ready);
    absorb_beat(b);
    burst_left--;
  endtask

  // Write every entry that the pixel is about to read and that was never written.
  task automatic fill_for_pixel(gmlct_pkg::pix_t p);
    logic [7:0] comp [CHANNELS];
    int         idx;
    comp[0] = p.red;
    comp[1] = p.green;
    comp[2] = p.blue;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!gamma_written[c][comp[c]])
        push_beat(table_beat(gmlct_pkg::ACT_GAMMA, 2'(c), TIDX_W'(comp[c]),
                             gamma_value()));
    end
    for (int j = 0; j < CHANNELS; j++) begin
      idx = lut_index(p, j);
      if (!lut_written[j][idx])
        push_beat(table_beat(gmlct_pkg::ACT_OUTPUT, 2'(j), TIDX_W'(idx),
                             TVAL_W'($urandom())));
    end
  endtask

  task automatic send_pixel(gmlct_pkg::pix_t p);
    fill_for_pixel(p);
    push_beat(p);
  endtask

  // Stop sending and let every beat, table writes included, leave the pipeline.
  task automatic wait_for_idle();
    pix_if.valid <= 1'b0;
    while (pixels_in_flight.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx <= gmlct_pkg::CFG_ROW_BLUE) matrix_mirror[idx] = value;
  endtask

  task automatic load_matrix(logic [ROW_W-1:0] red_row, logic [ROW_W-1:0] green_row,
                             logic [ROW_W-1:0] blue_row);
    wait_for_idle();
    write_cfg(gmlct_pkg::CFG_ROW_RED, red_row);
    write_cfg(gmlct_pkg::CFG_ROW_GREEN, green_row);
    write_cfg(gmlct_pkg::CFG_ROW_BLUE, blue_row);
  endtask

  task automatic send_random_pixels(int count);
    repeat (count) send_pixel(pixel_beat(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                         8'($urandom()), 1'($urandom())));
  endtask

  // Load entries on demand through the identity matrix, then rewrite some.
  task automatic test_table_load();
    gmlct_pkg::pix_t p;
    send_random_pixels(16);
    for (int k = 0; k < 4; k++) begin
      p = pixel_beat(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                     1'b0);
      send_pixel(p);
      push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_GREEN, TIDX_W'(p.green),
                           gamma_value()));
      push_beat(table_beat(gmlct_pkg::ACT_OUTPUT, CH_RED, TIDX_W'(lut_index(p, 0)),
                           TVAL_W'($urandom())));
      send_pixel(p);
    end
  endtask

  // Field extremes and the ignored or clamped cases, identity matrix.
  task automatic test_special_cases();
    // Zero gamma at index 0, and one above, at and below unity at index 255.
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_RED, 13'd0, 17'h00000));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_GREEN, 13'd0, 17'h00000));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_BLUE, 13'd0, 17'h00000));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_RED, 13'd255, 17'h1FFFF));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_GREEN, 13'd255, 17'h10000));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_BLUE, 13'd255, 17'h08000));
    // Output byte written with upper value bits set; only the low byte counts.
    push_beat(table_beat(gmlct_pkg::ACT_OUTPUT, CH_RED, 13'd8191, 17'h1FF5A));
    push_beat(table_beat(gmlct_pkg::ACT_OUTPUT, CH_GREEN, 13'd8191, 17'h000FF));
    send_pixel(pixel_beat(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    // Large sums clamp to the last entry; half of unity lands mid-table.
    send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    // Writes that must be dropped: bad channel, gamma index past the table, unused action.
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_NONE, 13'd0, 17'h1FFFF));
    push_beat(table_beat(gmlct_pkg::ACT_OUTPUT, CH_NONE, 13'd0, 17'h1FFFF));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_RED, 13'd256, 17'h01234));
    push_beat(table_beat(gmlct_pkg::ACT_GAMMA, CH_GREEN, 13'd8191, 17'h1FFFF));
    push_beat(table_beat(ACT_UNUSED, CH_RED, 13'd0, 17'h1FFFF));
    send_pixel(pixel_beat(8'h00, 8'h00, 8'h00, 8'hA5, 1'b0));
    // A fresh output write is seen by the very next pixel.
    push_beat(table_beat(gmlct_pkg::ACT_OUTPUT, CH_BLUE, 13'd0, 17'h1FFFF));
    send_pixel(pixel_beat(8'h00, 8'h00, 8'h00, 8'h5A, 1'b1));
    send_pixel(pixel_beat(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
  endtask

  // Matrix settings at the extremes, with a write to the unused index in between.
  task automatic test_matrix_settings();
    logic [ROW_W-1:0] settings [6][CHANNELS];
    settings[0] = '{48'h0, 48'h0, 48'h0};
    settings[1] = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF};
    settings[2] = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000};
    settings[3] = '{48'h0000_8000_7FFF, 48'h7FFF_0000_8000, 48'h8000_7FFF_0000};
    settings[4] = '{ROW_W'({$urandom(), $urandom()}), ROW_W'({$urandom(), $urandom()}),
                    ROW_W'({$urandom(), $urandom()})};
    settings[5] = '{gmlct_pkg::ROW_RED_RST, gmlct_pkg::ROW_GREEN_RST,
                    gmlct_pkg::ROW_BLUE_RST};
    foreach (settings[s]) begin
      load_matrix(settings[s][0], settings[s][1], settings[s][2]);
      write_cfg(CFG_IDX_UNUSED, ROW_W'({$urandom(), $urandom()}));
      send_random_pixels(SETTING_PIXELS);
    end
  endtask

  // Mixed traffic: mostly pixels, table rewrites, some dropped beats.
  task automatic test_random_traffic();
    int              taken;
    int              next_reload;
    int              roll;
    gmlct_pkg::pix_t b;
    taken       = 0;
    next_reload = 0;
    while (taken < RANDOM_ITEMS) begin
      if (taken >= next_reload) begin
        load_matrix(random_row(), random_row(), random_row());
        next_reload += RELOAD_EVERY;
      end
      b    = random_beat();
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        b.action = gmlct_pkg::ACT_PIXEL;
      end else if (roll < 75) begin
        b.action        = gmlct_pkg::ACT_GAMMA;
        b.table_channel = 2'($urandom_range(0, gmlct_pkg::CH_LAST));
        b.table_index   = TIDX_W'($urandom_range(0, GAMMA_DEPTH - 1));
        b.table_value   = gamma_value();
      end else if (roll < 90) begin
        b.action        = gmlct_pkg::ACT_OUTPUT;
        b.table_channel = 2'($urandom_range(0, gmlct_pkg::CH_LAST));
      end else begin
        case ($urandom_range(0, 2))
          0: b.action = ACT_UNUSED;
          1: begin
            b.action        = ($urandom_range(0, 1) == 0) ? gmlct_pkg::ACT_GAMMA
                                                          : gmlct_pkg::ACT_OUTPUT;
            b.table_channel = CH_NONE;
          end
          default: begin
            b.action      = gmlct_pkg::ACT_GAMMA;
            b.table_index = TIDX_W'($urandom_range(GAMMA_DEPTH, 8191));
          end
        endcase
      end
      if (b.action == gmlct_pkg::ACT_PIXEL) begin
        send_pixel(b);
      end else begin
        push_beat(b);
      end
      if (roll < 90) taken++;
    end
  endtask

  // Main sequence.
  initial begin
    mismatch_count = 0;
    burst_left     = 0;
    matrix_mirror  = '{gmlct_pkg::ROW_RED_RST, gmlct_pkg::ROW_GREEN_RST,
                       gmlct_pkg::ROW_BLUE_RST};
    rst_ni       <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= gmlct_pkg::CFG_ROW_RED;
    cfg_data_i   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_load();
    test_special_cases();
    test_matrix_settings();
    test_random_traffic();
    wait_for_idle();

    if (mismatch_count == 0 && pixels_in_flight.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/gmlct_pkg.sv
sv/gmlct_if.sv
sv/gmlct_gamma_lookup.sv
sv/gmlct_matrix_mult.sv
sv/gmlct_out_index.sv
sv/gmlct_out_lookup.sv
sv/gamma_matrix_lut_color_transform.sv
sv/gmlct_checker.sv
tb/testbench.sv
